@@ design/dpr_pkg.sv @@
package dpr_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 2;
	localparam int PIX_W     = 16;
	localparam int ENT_W     = PIX_W + 1;

	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int CMP_W = ((CNT_W > WW) ? CNT_W : WW) + 3;

	// ring must span 4W+3 entries; power of two keeps the wrap a plain truncation
	localparam int AW         = $clog2(4 * MAX_WIDTH + 3);
	localparam int RING_DEPTH = 2 ** AW;

	localparam int NBR_N   = 8;
	localparam int K_W     = $clog2(NBR_N + 1);
	localparam int NCNT_W  = $clog2(NBR_N + 1);
	localparam int SUM_W   = PIX_W + $clog2(NBR_N);
	localparam int NUM_W   = SUM_W + 1;
	localparam int DEN_W   = NCNT_W + 1;
	localparam int STEP_W  = $clog2(NUM_W);

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

	localparam int RST_FRAME_WIDTH  = 640;
	localparam int RST_FRAME_HEIGHT = 512;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SELF,
		ST_NBR,
		ST_DIV,
		ST_HOLD
	} mu_state_t;

	typedef struct packed {
		logic [WW-1:0] w;
		logic [HW-1:0] h;
	} geom_t;

	typedef struct packed {
		logic             valid;
		logic [CNT_W-1:0] idx;
		logic [WW-1:0]    x;
		logic [HW-1:0]    y;
		logic             last;
	} req_t;

	typedef struct packed {
		logic             we;
		logic [AW-1:0]    addr;
		logic [ENT_W-1:0] data;
	} wr_t;

	function automatic logic [WW-1:0] clamp_w(input logic [CFG_W-1:0] v);
		logic [WW-1:0] r;
		if (v == '0)
			r = WW'(1);
		else if (int'(v) > MAX_WIDTH)
			r = WW'(MAX_WIDTH);
		else
			r = WW'(v);
		return r;
	endfunction

	function automatic logic [HW-1:0] clamp_h(input logic [CFG_W-1:0] v);
		logic [HW-1:0] r;
		if (v == '0)
			r = HW'(1);
		else if (int'(v) > MAX_HEIGHT)
			r = HW'(MAX_HEIGHT);
		else
			r = HW'(v);
		return r;
	endfunction

	localparam logic [WW-1:0]    W_RST     = clamp_w(CFG_W'(RST_FRAME_WIDTH));
	localparam logic [HW-1:0]    H_RST     = clamp_h(CFG_W'(RST_FRAME_HEIGHT));
	localparam logic [CNT_W-1:0] TOTAL_RST = CNT_W'(int'(W_RST) * int'(H_RST));

endpackage

@@ design/dpr_if.sv @@
interface dpr_in_if;
	import dpr_pkg::*;
	logic             valid;
	logic             ready;
	logic             op;
	logic [PIX_W-1:0] pixel_value;
	logic             is_bad;

	modport source(output valid, output op, output pixel_value, output is_bad, input ready);
	modport sink(input valid, input op, input pixel_value, input is_bad, output ready);
endinterface

interface dpr_out_if;
	import dpr_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_out;
	logic             was_replaced;
	logic             no_good_neighbor;
	logic             last_of_frame;

	modport source(output valid, output pixel_out, output was_replaced,
		output no_good_neighbor, output last_of_frame, input ready);
	modport sink(input valid, input pixel_out, input was_replaced,
		input no_good_neighbor, input last_of_frame, output ready);
endinterface

interface dpr_cfg_if;
	import dpr_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

@@ design/dpr_ram.sv @@
module dpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

@@ design/dpr_frame_ctl.sv @@
module dpr_frame_ctl (
	input  logic           clk,
	input  logic           arst_n,
	dpr_cfg_if.sink        cfg,
	dpr_in_if.sink         px_in,
	input  logic           busy,
	output dpr_pkg::geom_t geom,
	output dpr_pkg::req_t  req,
	output dpr_pkg::wr_t   wr
);
	import dpr_pkg::*;

	logic [WW-1:0]    w_q;
	logic [HW-1:0]    h_q;
	logic [CNT_W-1:0] total_q;
	logic [CNT_W-1:0] item_cnt_q;
	logic [CNT_W-1:0] o_q;
	logic [WW-1:0]    x_q;
	logic [HW-1:0]    y_q;

	logic              cfg_hit;
	logic [WW-1:0]     w_new;
	logic [HW-1:0]     h_new;
	logic [WW+HW-1:0]  prod;
	logic              accept;
	logic              complete;
	logic              wr_en;
	logic              emit;
	logic              last;
	logic [CMP_W-1:0]  cnt_inc;
	logic [CMP_W-1:0]  o_lag;

	assign cfg.ready   = 1'b1;
	assign px_in.ready = !busy && !cfg.valid;

	assign cfg_hit = cfg.valid && cfg.ready &&
		(cfg.index == REG_FRAME_WIDTH || cfg.index == REG_FRAME_HEIGHT);
	assign w_new = (cfg.index == REG_FRAME_WIDTH)  ? clamp_w(cfg.data) : w_q;
	assign h_new = (cfg.index == REG_FRAME_HEIGHT) ? clamp_h(cfg.data) : h_q;
	assign prod  = (WW+HW)'(w_new) * (WW+HW)'(h_new);

	assign accept   = px_in.valid && px_in.ready;
	assign complete = item_cnt_q >= total_q;
	assign cnt_inc  = CMP_W'(item_cnt_q) + CMP_W'(1);
	// lag = 2W+2
	assign o_lag    = CMP_W'(o_q) + (CMP_W'(w_q) << 1) + CMP_W'(2);
	assign wr_en    = accept && !px_in.op && !complete;
	assign emit     = accept && (complete || (!px_in.op && cnt_inc > o_lag));
	assign last     = (CMP_W'(o_q) + CMP_W'(1)) == CMP_W'(total_q);

	assign geom.w = w_q;
	assign geom.h = h_q;

	assign req.valid = emit;
	assign req.idx   = o_q;
	assign req.x     = x_q;
	assign req.y     = y_q;
	assign req.last  = last;

	assign wr.we   = wr_en;
	assign wr.addr = item_cnt_q[AW-1:0];
	assign wr.data = {px_in.is_bad, px_in.pixel_value};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q        <= W_RST;
			h_q        <= H_RST;
			total_q    <= TOTAL_RST;
			item_cnt_q <= '0;
			o_q        <= '0;
			x_q        <= '0;
			y_q        <= '0;
		end else if (cfg_hit) begin
			w_q        <= w_new;
			h_q        <= h_new;
			total_q    <= prod[CNT_W-1:0];
			item_cnt_q <= '0;
			o_q        <= '0;
			x_q        <= '0;
			y_q        <= '0;
		end else begin
			if (wr_en)
				item_cnt_q <= cnt_inc[CNT_W-1:0];
			if (emit) begin
				if (last) begin
					// frame done, next pixel opens a new frame
					item_cnt_q <= '0;
					o_q        <= '0;
					x_q        <= '0;
					y_q        <= '0;
				end else begin
					o_q <= o_q + CNT_W'(1);
					if (x_q + WW'(1) == w_q) begin
						x_q <= '0;
						y_q <= y_q + HW'(1);
					end else begin
						x_q <= x_q + WW'(1);
					end
				end
			end
		end
	end

	a_cnt_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		item_cnt_q <= total_q)
		else $error("pixel count ran past frame size");

	a_out_behind_in: assert property (@(posedge clk) disable iff (!arst_n)
		o_q <= item_cnt_q)
		else $error("output position ahead of stored pixels");

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last && !cfg_hit) |=> (item_cnt_q == '0 && o_q == '0))
		else $error("frame end did not restart counters");
endmodule

@@ design/dpr_mean_unit.sv @@
module dpr_mean_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dpr_pkg::geom_t            geom,
	input  dpr_pkg::req_t             req,
	output logic                      busy,
	output logic [dpr_pkg::AW-1:0]    rd_addr,
	input  logic [dpr_pkg::ENT_W-1:0] rd_data,
	dpr_out_if.source                 px_out
);
	import dpr_pkg::*;

	mu_state_t state_q;
	mu_state_t state_nx;

	logic [AW-1:0]     idx_q;
	logic [WW-1:0]     x_q;
	logic [HW-1:0]     y_q;
	logic              last_q;
	logic [PIX_W-1:0]  pix_q;
	logic [SUM_W-1:0]  sum_q;
	logic [NCNT_W-1:0] cnt_q;
	logic [K_W-1:0]    k_q;
	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [STEP_W-1:0] step_q;
	logic [PIX_W-1:0]  res_q;
	logic              repl_q;
	logic              none_q;

	logic              ov_q;
	logic [PIX_W-1:0]  pixel_out_q;
	logic              was_replaced_q;
	logic              no_good_q;
	logic              last_out_q;

	logic [NBR_N-1:0]  mask;
	logic [K_W-1:0]    km1;
	logic              take;
	logic [SUM_W-1:0]  sum_nx;
	logic [NCNT_W-1:0] cnt_nx;
	logic [NUM_W-1:0]  num_init;
	logic [DEN_W-1:0]  den_init;
	logic [DEN_W:0]    trial;
	logic              q_bit;
	logic [DEN_W-1:0]  rem_nx;
	logic [NUM_W-1:0]  quo_nx;
	logic              div_last;
	logic              load;
	logic [AW-1:0]     w_a;

	assign w_a = AW'(geom.w);

	function automatic logic [AW-1:0] nbr_addr(input logic [2:0] k, input logic [AW-1:0] c,
		input logic [AW-1:0] w);
		logic [AW-1:0] a;
		case (k)
			3'd0:    a = c - AW'(1);
			3'd1:    a = c - AW'(2);
			3'd2:    a = c + AW'(1);
			3'd3:    a = c + AW'(2);
			3'd4:    a = c - w;
			3'd5:    a = c - (w << 1);
			3'd6:    a = c + w;
			3'd7:    a = c + (w << 1);
			default: a = c;
		endcase
		return a;
	endfunction

	// neighbour order: left 1, left 2, right 1, right 2, up 1, up 2, down 1, down 2
	assign mask[0] = x_q != '0;
	assign mask[1] = x_q > WW'(1);
	assign mask[2] = ((WW+1)'(x_q) + (WW+1)'(1)) < (WW+1)'(geom.w);
	assign mask[3] = ((WW+1)'(x_q) + (WW+1)'(2)) < (WW+1)'(geom.w);
	assign mask[4] = y_q != '0;
	assign mask[5] = y_q > HW'(1);
	assign mask[6] = ((HW+1)'(y_q) + (HW+1)'(1)) < (HW+1)'(geom.h);
	assign mask[7] = ((HW+1)'(y_q) + (HW+1)'(2)) < (HW+1)'(geom.h);

	// read data in NBR belongs to the neighbour addressed in the previous cycle
	assign km1    = k_q - K_W'(1);
	assign take   = mask[km1[2:0]] && !rd_data[ENT_W-1];
	assign sum_nx = take ? sum_q + SUM_W'(rd_data[PIX_W-1:0]) : sum_q;
	assign cnt_nx = take ? cnt_q + NCNT_W'(1) : cnt_q;

	// round half up: (2*sum + n) / (2*n)
	assign num_init = {sum_nx, 1'b0} + NUM_W'(cnt_nx);
	assign den_init = {cnt_nx, 1'b0};

	assign trial    = {rem_q, num_q[NUM_W-1]};
	assign q_bit    = trial >= {1'b0, den_q};
	assign rem_nx   = q_bit ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
	assign quo_nx   = {num_q[NUM_W-2:0], q_bit};
	assign div_last = step_q == STEP_W'(NUM_W - 1);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid)
					state_nx = ST_SELF;
			end
			ST_SELF: begin
				state_nx = rd_data[ENT_W-1] ? ST_NBR : ST_HOLD;
			end
			ST_NBR: begin
				if (k_q == K_W'(NBR_N))
					state_nx = (cnt_nx == '0) ? ST_HOLD : ST_DIV;
			end
			ST_DIV: begin
				if (div_last)
					state_nx = ST_HOLD;
			end
			ST_HOLD: begin
				if (!ov_q || px_out.ready)
					state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		busy    = state_q != ST_IDLE;
		load    = 1'b0;
		rd_addr = idx_q;
		case (state_q)
			ST_IDLE: rd_addr = req.idx[AW-1:0];
			ST_SELF: rd_addr = nbr_addr(3'd0, idx_q, w_a);
			ST_NBR:  rd_addr = nbr_addr(k_q[2:0], idx_q, w_a);
			ST_HOLD: load    = !ov_q || px_out.ready;
			default: rd_addr = idx_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (load)
				ov_q <= 1'b1;
			else if (px_out.ready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					idx_q  <= req.idx[AW-1:0];
					x_q    <= req.x;
					y_q    <= req.y;
					last_q <= req.last;
				end
			end
			ST_SELF: begin
				pix_q  <= rd_data[PIX_W-1:0];
				res_q  <= rd_data[PIX_W-1:0];
				repl_q <= 1'b0;
				none_q <= 1'b0;
				k_q    <= K_W'(1);
				sum_q  <= '0;
				cnt_q  <= '0;
			end
			ST_NBR: begin
				sum_q <= sum_nx;
				cnt_q <= cnt_nx;
				k_q   <= k_q + K_W'(1);
				if (k_q == K_W'(NBR_N)) begin
					num_q  <= num_init;
					den_q  <= den_init;
					rem_q  <= '0;
					step_q <= '0;
					res_q  <= pix_q;
					none_q <= cnt_nx == '0;
				end
			end
			ST_DIV: begin
				num_q  <= quo_nx;
				rem_q  <= rem_nx;
				step_q <= step_q + STEP_W'(1);
				if (div_last) begin
					res_q  <= quo_nx[PIX_W-1:0];
					repl_q <= 1'b1;
				end
			end
			default: ;
		endcase
		if (load) begin
			pixel_out_q    <= res_q;
			was_replaced_q <= repl_q;
			no_good_q      <= none_q;
			last_out_q     <= last_q;
		end
	end

	assign px_out.valid            = ov_q;
	assign px_out.pixel_out        = pixel_out_q;
	assign px_out.was_replaced     = was_replaced_q;
	assign px_out.no_good_neighbor = no_good_q;
	assign px_out.last_of_frame    = last_out_q;

	a_req_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid |-> state_q == ST_IDLE)
		else $error("emit request while a pixel is in work");

	a_quot_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && div_last) |-> quo_nx[NUM_W-1:PIX_W] == '0)
		else $error("neighbour mean overflowed the sample width");

	a_hold_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HOLD && !ov_q) |=> ov_q)
		else $error("finished word not moved to output register");
endmodule

@@ design/defective_pixel_neighbor_replace.sv @@
// Defective pixel correction by neighbour mean.
// px_in takes raster-order words (op 0 = pixel with bad flag, op 1 = flush);
// px_out gives each pixel again, 2W+2 pixel words later, with a bad pixel
// replaced by the rounded mean of its good neighbours (two each way, inside
// the frame). Flush words drain the pixels still held at frame end.
// cfg writes frame_width (index 0) or frame_height (index 1); a write
// restarts the frame. Write only while no word is in work.
// Throughput: one word per cycle while no result is due and no cfg write is
// offered. A word that emits a pixel keeps px_in closed while the result is
// made: self read; for a bad pixel, eight neighbour reads on the single ring
// read port; if any neighbour is good, the 20-step serial divider; then the
// output handoff, which moves the result into the output register.
// The output register lets a new word in while px_out is stalled; a
// finished result then waits until the register frees.
// Reset clears counters and output valid and sets 640x512; the pixel ring
// is not cleared, and only entries written in the current frame are used.
module defective_pixel_neighbor_replace (
	input  logic      clk,
	input  logic      arst_n,
	dpr_cfg_if.sink   cfg,
	dpr_in_if.sink    px_in,
	dpr_out_if.source px_out
);
	import dpr_pkg::*;

	geom_t            geom;
	req_t             req;
	wr_t              wr;
	logic             busy;
	logic [AW-1:0]    rd_addr;
	logic [ENT_W-1:0] rd_data;

	dpr_frame_ctl u_ctl (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.px_in  (px_in),
		.busy   (busy),
		.geom   (geom),
		.req    (req),
		.wr     (wr)
	);

	dpr_ram #(
		.WIDTH (ENT_W),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (wr.we),
		.waddr (wr.addr),
		.wdata (wr.data),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	dpr_mean_unit u_mean (
		.clk     (clk),
		.arst_n  (arst_n),
		.geom    (geom),
		.req     (req),
		.busy    (busy),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.px_out  (px_out)
	);
endmodule
